>>> design/mlbd_pkg.sv
// Package for the mip level box downsampler.
// Holds register codes and the elaboration-time builders of the sRGB tables.
// No dependencies.
`default_nettype none
package mlbd_pkg;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_SRGB_MODE     = 2'd2
	} reg_index_t;

	localparam int CfgDataBits = 13;
	localparam int CodeBits    = 8;

	typedef logic [31:0] lin_tab_t [256];

	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned pow5(longint unsigned r);
		longint unsigned t;
		t = r;
		for (int i = 0; i < 4; i++) t = qmul(t, r);
		return t;
	endfunction

	// linear light at sRGB value n/510, rounded to an f-bit fraction
	function automatic logic [31:0] lin_at(int unsigned n, int unsigned f);
		longint unsigned lin_max;
		longint unsigned num;
		longint unsigned p;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned y;
		lin_max = (64'd1 << f) - 64'd1;
		if (n <= 20) begin
			num = 64'd100 * n * lin_max;
			return 32'((num + 64'd329460) / 64'd658920);
		end
		p = 64'd1000 * n + 64'd28050;
		u = ((p << 30) + 64'd269025) / 64'd538050;
		if (u > (64'd1 << 30)) u = 64'd1 << 30;
		u2 = qmul(u, u);
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = lo + (hi - lo + 64'd1) / 64'd2;
			if (pow5(mid) <= u2) lo = mid;
			else hi = mid - 64'd1;
		end
		y = qmul(u2, lo);
		return 32'((y * lin_max + (64'd1 << 29)) >> 30);
	endfunction

	function automatic lin_tab_t build_decode(int unsigned f);
		lin_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = lin_at(2 * i, f);
		return t;
	endfunction

	function automatic lin_tab_t build_breaks(int unsigned f);
		lin_tab_t t;
		t[0] = '0;
		for (int k = 1; k < 256; k++) t[k] = lin_at(2 * k - 1, f);
		return t;
	endfunction

endpackage
`default_nettype wire

>>> design/mip_level_box_downsampler_core.sv
// Mip level box downsampler: RGBA8 raster in, half-size level out.
// Uses mlbd_pkg and mlbd_encoder.
//
// Source pixels enter on in_* with in_valid/in_stall, in raster order of a
// source_width x source_height level. Each 2x2 block gives one destination
// pixel on out_* with out_valid/out_stall; last_pixel marks the final one.
// A width or height of 1 counts each pixel twice; an odd last row or column
// is dropped. srgb_mode averages RGB in linear light.
// The pair sums of the even row sit in a synchronous line memory,
// written by the even row and read back by the odd row one row later.
// Throughput: one pixel per cycle while in_stall is low. From acceptance of the
// pixel that completes a block to out_valid, the item passes the stage 1 register,
// the line memory read, the encoder input register and one encoder stage per sRGB code bit.
// Reset empties the pipeline, clears the raster counters and sets the level
// to 1x1, linear mode. A write to any of the three registers restarts the level.
// When the receiver stalls, the pipeline fills behind the output register
// and in_stall rises only once all stages hold an item.
`default_nettype none
module mip_level_box_downsampler_core import mlbd_pkg::*; #(
	parameter int MAX_WIDTH        = 4096,
	parameter int LINEAR_FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write_enable,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CfgDataBits-1:0] cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             in_red,
	input  wire logic [7:0]             in_green,
	input  wire logic [7:0]             in_blue,
	input  wire logic [7:0]             in_alpha,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [7:0]                  out_red,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_blue,
	output logic [7:0]                  out_alpha,
	output logic                        last_pixel
);

	localparam int F     = LINEAR_FRAC_BITS;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = F + 1;
	localparam int MW    = 3 * PW + 9;
	localparam lin_tab_t DEC_TAB = build_decode(F);

	logic [12:0] src_width_q, src_height_q;
	logic        srgb_q;
	logic [CW-1:0] col_q;
	logic [12:0]   row_q;
	logic [F-1:0]  held_rgb_q [3];
	logic [7:0]    held_alpha_q;

	// stage 0: decode, horizontal pairing, raster position
	logic [CW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic          w1, h1, accept;
	logic [7:0]    pix [3];
	logic [F-1:0]  v_rgb [3];
	logic [PW-1:0] pair_rgb [3];
	logic [8:0]    pair_alpha;
	logic          have_pair, wr0, emit0, last0;
	logic [CW-1:0] x_full, dw, col_inc;
	logic [12:0]   y0, dh;
	logic [13:0]   row_inc;

	assign pix[0] = in_red;
	assign pix[1] = in_green;
	assign pix[2] = in_blue;

	always_comb begin
		if (src_width_q == 13'd0) w_eff = CW'(1);
		else if (32'(src_width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(src_width_q);
		h_eff = (src_height_q == 13'd0) ? 13'd1 : src_height_q;
		w1 = (w_eff == CW'(1));
		h1 = (h_eff == 13'd1);
		for (int i = 0; i < 3; i++) begin
			v_rgb[i]    = srgb_q ? DEC_TAB[pix[i]][F-1:0] : F'(pix[i]);
			pair_rgb[i] = w1 ? {v_rgb[i], 1'b0} : PW'(held_rgb_q[i]) + PW'(v_rgb[i]);
		end
		pair_alpha = w1 ? {in_alpha, 1'b0} : 9'(held_alpha_q) + 9'(in_alpha);
		have_pair  = w1 || col_q[0];
		x_full     = w1 ? '0 : (col_q >> 1);
		col_inc    = col_q + CW'(1);
		row_inc    = 14'(row_q) + 14'd1;
		wr0        = !h1 && !row_q[0] && (row_inc < 14'(h_eff));
		emit0      = h1 || row_q[0];
		dw         = ((w_eff >> 1) == '0) ? CW'(1) : (w_eff >> 1);
		dh         = ((h_eff >> 1) == '0) ? 13'd1 : (h_eff >> 1);
		y0         = h1 ? 13'd0 : (row_q >> 1);
		last0      = (x_full == dw - CW'(1)) && (y0 == dh - 13'd1);
	end

	// stage 1 / stage 2 handshake
	logic v_s1, v_s2, free_s1, free_s2, enc_stall;
	assign free_s2  = !v_s2 || !enc_stall;
	assign free_s1  = !v_s1 || free_s2;
	assign in_stall = !free_s1;
	assign accept   = in_valid && !in_stall;

	logic          go0;
	assign go0 = accept && have_pair && (32'(x_full) < DEPTH) && (wr0 || emit0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 13'd1;
			src_height_q <= 13'd1;
			srgb_q       <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				REG_SOURCE_WIDTH: begin
					src_width_q <= cfg_data;
					col_q <= '0;
					row_q <= '0;
				end
				REG_SOURCE_HEIGHT: begin
					src_height_q <= cfg_data;
					col_q <= '0;
					row_q <= '0;
				end
				REG_SRGB_MODE: begin
					srgb_q <= cfg_data[0];
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= 14'(h_eff)) ? 13'd0 : row_inc[12:0];
			end else begin
				col_q <= col_inc;
			end
		end
	end

	// left pixel is always written before it is read within a row
	always_ff @(posedge clk) begin
		if (accept && !w1 && !col_q[0] && (col_inc < w_eff)) begin
			held_rgb_q   <= v_rgb;
			held_alpha_q <= in_alpha;
		end
	end

	logic [PW-1:0] pair_rgb_s1 [3];
	logic [8:0]    pair_alpha_s1;
	logic [AW-1:0] x_s1;
	logic          wr_s1, emit_s1, h1_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (free_s1) v_s1 <= go0;
	end

	always_ff @(posedge clk) begin
		if (free_s1 && go0) begin
			pair_rgb_s1   <= pair_rgb;
			pair_alpha_s1 <= pair_alpha;
			x_s1          <= x_full[AW-1:0];
			wr_s1         <= wr0;
			emit_s1       <= emit0;
			h1_s1         <= h1;
			last_s1       <= last0;
		end
	end

	// line memory: even row writes pair sums, odd row reads them a row later
	logic [MW-1:0] line_mem [DEPTH];
	logic [MW-1:0] rd_s2;
	logic          leave_s1;
	assign leave_s1 = v_s1 && free_s2;

	always_ff @(posedge clk) begin
		if (leave_s1 && wr_s1) begin
			line_mem[x_s1] <= {pair_rgb_s1[0], pair_rgb_s1[1], pair_rgb_s1[2], pair_alpha_s1};
		end
		if (leave_s1) rd_s2 <= line_mem[x_s1];
	end

	logic [PW-1:0] pair_rgb_s2 [3];
	logic [8:0]    pair_alpha_s2;
	logic          h1_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (free_s2) v_s2 <= v_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (leave_s1) begin
			pair_rgb_s2   <= pair_rgb_s1;
			pair_alpha_s2 <= pair_alpha_s1;
			h1_s2         <= h1_s1;
			last_s2       <= last_s1;
		end
	end

	logic [F+1:0] tot_rgb [3];
	logic [9:0]   tot_alpha;
	logic [PW-1:0] rd_rgb [3];
	logic [8:0]    rd_alpha;

	always_comb begin
		rd_rgb[0] = rd_s2[MW-1 -: PW];
		rd_rgb[1] = rd_s2[MW-1-PW -: PW];
		rd_rgb[2] = rd_s2[MW-1-2*PW -: PW];
		rd_alpha  = rd_s2[8:0];
		for (int i = 0; i < 3; i++) begin
			tot_rgb[i] = h1_s2 ? {pair_rgb_s2[i], 1'b0}
			                   : (F+2)'(rd_rgb[i]) + (F+2)'(pair_rgb_s2[i]);
		end
		tot_alpha = h1_s2 ? {pair_alpha_s2, 1'b0} : 10'(rd_alpha) + 10'(pair_alpha_s2);
	end

	logic [7:0] enc_rgb [3];

	mlbd_encoder #(.F(F)) u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_stall  (enc_stall),
		.srgb      (srgb_q),
		.tot_rgb   (tot_rgb),
		.tot_alpha (tot_alpha),
		.in_last   (last_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rgb   (enc_rgb),
		.out_alpha (out_alpha),
		.out_last  (last_pixel)
	);

	assign out_red   = enc_rgb[0];
	assign out_green = enc_rgb[1];
	assign out_blue  = enc_rgb[2];

endmodule
`default_nettype wire

>>> design/mlbd_encoder.sv
// Output pipeline: rounds linear sums or sRGB-encodes them by binary search
// over the breakpoint table, one code bit per stage. Uses mlbd_pkg.
`default_nettype none
module mlbd_encoder import mlbd_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         srgb,
	input  wire logic [F+1:0] tot_rgb [3],
	input  wire logic [9:0]   tot_alpha,
	input  wire logic         in_last,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        out_rgb [3],
	output logic [7:0]        out_alpha,
	output logic              out_last
);

	localparam int NS = CodeBits + 1;
	localparam lin_tab_t BRK_TAB = build_breaks(F);

	logic         v_q     [NS];
	logic [F+1:0] sum_q   [NS][3];
	logic [7:0]   code_q  [NS][3];
	logic [7:0]   alpha_q [NS];
	logic         last_q  [NS];
	logic         free    [NS];

	genvar k, c;
	generate
		for (k = 0; k < NS; k++) begin : g_free
			if (k == NS - 1) begin : g_end
				assign free[k] = !v_q[k] || !out_stall;
			end else begin : g_mid
				assign free[k] = !v_q[k] || free[k+1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[0] <= 1'b0;
			end else if (free[0]) begin
				v_q[0] <= in_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (free[0] && in_valid) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[0][i]  <= tot_rgb[i];
					code_q[0][i] <= srgb ? 8'd0 : 8'((tot_rgb[i] + (F+2)'(2)) >> 2);
				end
				alpha_q[0] <= 8'((tot_alpha + 10'd2) >> 2);
				last_q[0]  <= in_last;
			end
		end

		for (k = 1; k < NS; k++) begin : g_stage
			localparam int BITPOS = CodeBits - k;
			logic [7:0] nxt [3];
			for (c = 0; c < 3; c++) begin : g_ch
				logic [7:0]   t;
				logic [F+1:0] brk4;
				assign t    = code_q[k-1][c] | 8'(1 << BITPOS);
				assign brk4 = {BRK_TAB[t][F-1:0], 2'b00};
				assign nxt[c] = (srgb && brk4 <= sum_q[k-1][c]) ? t : code_q[k-1][c];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (free[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (free[k] && v_q[k-1]) begin
					for (int i = 0; i < 3; i++) begin
						sum_q[k][i]  <= sum_q[k-1][i];
						code_q[k][i] <= nxt[i];
					end
					alpha_q[k] <= alpha_q[k-1];
					last_q[k]  <= last_q[k-1];
				end
			end
		end
	endgenerate

	assign in_stall  = !free[0];
	assign out_valid = v_q[NS-1];
	assign out_alpha = alpha_q[NS-1];
	assign out_last  = last_q[NS-1];
	always_comb begin
		for (int i = 0; i < 3; i++) out_rgb[i] = code_q[NS-1][i];
	end

endmodule
`default_nettype wire

>>> design/mlbd_checker.sv
// Port-level checks for mip_level_box_downsampler_core, and its bind.
// Sees the top-level ports only; no package needed.
`default_nettype none
module mlbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] out_alpha,
	input wire logic       last_pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({out_red, out_green, out_blue, out_alpha, last_pixel}))
		else $error("stalled output item changed");

	// input backpressure only once the pipeline is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("pipeline not empty after reset");

endmodule

bind mip_level_box_downsampler_core mlbd_checker u_mlbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_red    (out_red),
	.out_green  (out_green),
	.out_blue   (out_blue),
	.out_alpha  (out_alpha),
	.last_pixel (last_pixel)
);
`default_nettype wire

>>> sim/tb_mip_level_box_downsampler_core.sv
// Testbench for mip_level_box_downsampler_core: directed and random mip levels.
// Depends on mlbd_pkg for the register codes and on the design files only.
// A local box-filter predictor with its own sRGB tables checks each result in order.
`default_nettype none
module tb_mip_level_box_downsampler_core import mlbd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_SLOTS = 2048;
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned LIN_ONE = 64'd65535;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_TARGET = 1400;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} dst_pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write_enable = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             out_red, out_green, out_blue, out_alpha;
	logic                   last_pixel;

	mip_level_box_downsampler_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	int unsigned decode_lut [256];
	int unsigned break_lut [256];
	int unsigned pair_store [ROW_SLOTS][4];
	int unsigned left_px [4];
	int unsigned pos_col, pos_row;
	int unsigned level_w = 1, level_h = 1;
	bit          srgb_on = 1'b0;
	dst_pixel_t  expected_q [$];

	bit  idle_on = 1'b1;
	int  fail_count = 0;
	int  pixels_sent = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_req = 0;
	longint cycles = 0;

	function automatic longint unsigned qmul30(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned fifth_power(longint unsigned r);
		longint unsigned acc;
		acc = r;
		repeat (4) acc = qmul30(acc, r);
		return acc;
	endfunction

	// linear light of sRGB value n/510 on a 16-bit fraction scale
	function automatic int unsigned srgb_to_lin(int unsigned n);
		longint unsigned u, u2, lo, hi, mid, y;
		if (n <= 20)
			return 32'((64'd100 * n * LIN_ONE + 64'd329460) / 64'd658920);
		u = (((64'd1000 * n + 64'd28050) << 30) + 64'd269025) / 64'd538050;
		if (u > Q30) u = Q30;
		u2 = qmul30(u, u);
		lo = 0;
		hi = Q30;
		// fifth root of u^2 by bisection, so y = u^2.4
		while (lo < hi) begin
			mid = lo + (hi - lo + 64'd1) / 64'd2;
			if (fifth_power(mid) <= u2) lo = mid;
			else hi = mid - 64'd1;
		end
		y = qmul30(u2, lo);
		return 32'((y * LIN_ONE + (64'd1 << 29)) >> 30);
	endfunction

	function automatic logic [7:0] lin_sum_to_code(int unsigned sum4);
		int unsigned code;
		code = 0;
		for (int k = 1; k < 256; k++)
			if (longint'(sum4) >= 4 * longint'(break_lut[k])) code++;
		return code[7:0];
	endfunction

	function automatic void restart_level();
		pos_col = 0;
		pos_row = 0;
		for (int c = 0; c < 4; c++) left_px[c] = 0;
	endfunction

	// box-filter prediction for one accepted source pixel
	function automatic void predict_box(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		int unsigned v [4], pair [4], tot [4];
		int unsigned x, y, dw, dh, res;
		logic [7:0] chan [4];
		bit paired, emit;
		dst_pixel_t d;
		chan = '{r, g, b, a};
		paired = 0;
		emit = 0;
		x = 0;
		for (int c = 0; c < 4; c++) v[c] = (c < 3 && srgb_on) ? decode_lut[chan[c]] : chan[c];
		if (level_w == 1) begin
			for (int c = 0; c < 4; c++) pair[c] = 2 * v[c];
			paired = 1;
		end else if (!pos_col[0]) begin
			if (pos_col + 1 < level_w) left_px = v;
		end else begin
			for (int c = 0; c < 4; c++) pair[c] = left_px[c] + v[c];
			x = pos_col >> 1;
			paired = 1;
		end
		if (paired) begin
			if (level_h == 1) begin
				for (int c = 0; c < 4; c++) tot[c] = 2 * pair[c];
				emit = 1;
			end else if (!pos_row[0]) begin
				if (pos_row + 1 < level_h) pair_store[x] = pair;
			end else begin
				for (int c = 0; c < 4; c++) tot[c] = pair_store[x][c] + pair[c];
				emit = 1;
			end
		end
		pos_col++;
		if (pos_col >= level_w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= level_h) pos_row = 0;
		end
		if (!emit) return;
		dw = (level_w / 2 < 1) ? 1 : level_w / 2;
		dh = (level_h / 2 < 1) ? 1 : level_h / 2;
		if (level_h == 1) y = 0;
		else if (pos_row == 0 && pos_col == 0) y = (level_h - 1) >> 1;
		else y = ((pos_col == 0) ? pos_row - 1 : pos_row) >> 1;
		for (int c = 0; c < 4; c++) begin
			res = (c < 3 && srgb_on) ? lin_sum_to_code(tot[c]) : ((tot[c] + 2) >> 2);
			chan[c] = res[7:0];
		end
		d.red = chan[0];
		d.green = chan[1];
		d.blue = chan[2];
		d.alpha = chan[3];
		d.last = (x == dw - 1 && y == dh - 1);
		expected_q = {expected_q, d};
	endfunction

	function automatic void apply_reg(logic [1:0] idx, int unsigned val);
		int unsigned v13;
		v13 = val & 32'h1FFF;
		case (idx)
			REG_SOURCE_WIDTH:  level_w = (v13 < 1) ? 1 : (v13 > 4096 ? 4096 : v13);
			REG_SOURCE_HEIGHT: level_h = (v13 < 1) ? 1 : v13;
			REG_SRGB_MODE:     srgb_on = v13[0];
			default:           return;
		endcase
		restart_level();
	endfunction

	// all tasks start and end just after a falling edge
	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_write_enable = 1'b1;
		cfg_index = idx;
		cfg_data = val[CfgDataBits-1:0];
		@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_write_enable = 1'b0;
	endtask

	task automatic set_level(int unsigned w, int unsigned h, bit srgb);
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
		write_reg(REG_SRGB_MODE, 32'(srgb));
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_red = r;
		in_green = g;
		in_blue = b;
		in_alpha = a;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_box(r, g, b, a);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_linear_extremes();
		set_level(2, 2, 0);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
		// odd width and height: last column and row are dropped
		write_reg(REG_SOURCE_WIDTH, 3);
		write_reg(REG_SOURCE_HEIGHT, 3);
		for (int i = 0; i < 9; i++) send_pixel(8'(i * 31), 8'hAA, 8'h55, 8'(255 - i));
		// unused index leaves the level alone
		write_reg(REG_NONE, 5);
		for (int i = 0; i < 9; i++) send_random_pixel();
	endtask

	task automatic test_srgb_curve();
		set_level(4, 2, 1);
		send_pixel(8'd0, 8'd10, 8'd11, 8'd0);
		send_pixel(8'd255, 8'd10, 8'd12, 8'd255);
		send_pixel(8'd128, 8'd1, 8'd200, 8'd7);
		send_pixel(8'd127, 8'd2, 8'd201, 8'd8);
		send_pixel(8'd0, 8'd10, 8'd11, 8'd1);
		send_pixel(8'd255, 8'd11, 8'd10, 8'd2);
		send_pixel(8'd64, 8'd255, 8'd0, 8'd3);
		send_pixel(8'd65, 8'd255, 8'd0, 8'd4);
	endtask

	task automatic test_clamped_edges();
		set_level(1, 1, 0);
		repeat (3) send_random_pixel();
		set_level(1, 3, 1);
		repeat (6) send_random_pixel();
		set_level(5, 1, 0);
		repeat (5) send_random_pixel();
		// zero sizes behave as 1x1
		set_level(0, 0, 1);
		repeat (3) send_random_pixel();
	endtask

	task automatic test_size_limits();
		// width saturates at the line memory size
		set_level(8191, 1, 0);
		repeat (600) send_random_pixel();
		set_level(4096, 4096, 1);
		repeat (40) send_random_pixel();
		set_level(2, 4096, 0);
		repeat (30) send_random_pixel();
	endtask

	task automatic test_backpressure();
		idle_on = 0;
		set_level(8, 4, 1);
		hold_req = 300;
		repeat (64) send_random_pixel();
		idle_on = 1;
	endtask

	task automatic test_random_levels();
		int unsigned w, h, n;
		while (pixels_sent < ITEM_TARGET) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			h = $urandom_range(1, 8);
			set_level(w, h, 1'($urandom_range(0, 1)));
			idle_on = $urandom_range(0, 3) != 0;
			// mostly whole levels, sometimes with wrap into the next, sometimes cut short
			case ($urandom_range(0, 5))
				0:       n = $urandom_range(1, w * h);
				1:       n = 2 * w * h;
				default: n = w * h;
			endcase
			for (int i = 0; i < n; i++) begin
				if (pixels_sent >= ITEM_TARGET) break;
				if (i == n / 2 && $urandom_range(0, 9) == 0) wait_drained();
				send_random_pixel();
			end
		end
		idle_on = 1;
	endtask

	// receiver: random stalls per result, plus long hold-offs on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		dst_pixel_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result pixel");
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (out_red !== e.red) begin
					$error("out_red exp %0d got %0d", e.red, out_red);
					fail_count++;
				end
				if (out_green !== e.green) begin
					$error("out_green exp %0d got %0d", e.green, out_green);
					fail_count++;
				end
				if (out_blue !== e.blue) begin
					$error("out_blue exp %0d got %0d", e.blue, out_blue);
					fail_count++;
				end
				if (out_alpha !== e.alpha) begin
					$error("out_alpha exp %0d got %0d", e.alpha, out_alpha);
					fail_count++;
				end
				if (last_pixel !== e.last) begin
					$error("last_pixel exp %0d got %0d", e.last, last_pixel);
					fail_count++;
				end
			end
			stall_left = idle_on ? $urandom_range(0, 5) : 0;
		end
	end

	initial begin
		decode_lut[0] = srgb_to_lin(0);
		break_lut[0] = 0;
		for (int i = 1; i < 256; i++) begin
			decode_lut[i] = srgb_to_lin(2 * i);
			break_lut[i] = srgb_to_lin(2 * i - 1);
		end
		restart_level();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_linear_extremes();
		test_srgb_curve();
		test_clamped_edges();
		test_size_limits();
		test_backpressure();
		test_random_levels();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
